FILE: rtl/rotated_sprite_blit_color_key_unit_assert.svh
// Assertion helpers shared by the checker of the rotated sprite blitter.
`ifndef ROTATED_SPRITE_BLIT_COLOR_KEY_UNIT_ASSERT_SVH
`define ROTATED_SPRITE_BLIT_COLOR_KEY_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSBCK_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSBCK_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/rsbck_pkg.sv
`default_nettype none
package rsbck_pkg;

   localparam int SCREEN_WIDTH      = 640;
   localparam int SCREEN_HEIGHT     = 480;
   localparam int MAX_SPRITE_TEXELS = 4096;

   localparam int ADDR_W      = $clog2(MAX_SPRITE_TEXELS);
   localparam int COLOR_W     = 24;
   localparam int POS_W       = 32;
   localparam int START_W     = 27;
   localparam int STEP_W      = 17;
   localparam int SIZE_W      = 7;
   localparam int COUNT_W     = 7;
   localparam int PIX_W       = 10;
   localparam int PROD_W      = COUNT_W - 1 + SIZE_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 27;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_FIELD_W = 2 * PIX_W + COLOR_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPRITE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPRITE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_COLOR     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_X       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_Y       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_COS      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SIN      = 3'd6;

   localparam logic [SIZE_W-1:0]        SIZE_MAX   = 7'd64;
   localparam logic [COLOR_W-1:0]       KEY_RESET  = 24'hffffff;
   localparam logic signed [STEP_W-1:0] COS_RESET  = 17'sd32768;
   localparam logic signed [POS_W:0]    HALF_Q     = 33'sd32768;
   localparam logic signed [POS_W:0]    NEG_LIMIT  = -33'sd65536;
   localparam logic signed [POS_W:0]    X_LIMIT    = 33'(SCREEN_WIDTH * 65536);
   localparam logic signed [POS_W:0]    Y_LIMIT    = 33'(SCREEN_HEIGHT * 65536);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_go;
      logic step_go;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
      logic [SIZE_W-1:0] r;
      r = s;
      if (s == '0) begin
         r = SIZE_W'(1);
      end else if (s > SIZE_MAX) begin
         r = SIZE_MAX;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/rsbck_ctrl.sv
`default_nettype none
module rsbck_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_func,
   input  wire rsbck_pkg::status_type status,
   output logic                       req_tready,
   output rsbck_pkg::cmd_type         cmd
);

   rsbck_pkg::state_type state_ff;
   rsbck_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsbck_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rsbck_pkg::ST_IDLE: begin
            if (req_tvalid && req_func) begin
               state_in = rsbck_pkg::ST_EMIT;
            end
         end
         rsbck_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = rsbck_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rsbck_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         rsbck_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_go = req_tvalid && !req_func;
            cmd.step_go = req_tvalid && req_func;
         end
         rsbck_pkg::ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: rtl/rsbck_datapath.sv
`default_nettype none
module rsbck_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   input  wire logic [rsbck_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [rsbck_pkg::CSR_DATA_W-1:0]     csr_data,
   input  wire logic [rsbck_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  wire rsbck_pkg::cmd_type                   cmd,
   output rsbck_pkg::status_type                     status,
   input  wire logic                                 rsp_tready,
   output logic                                      rsp_tvalid,
   output logic [rsbck_pkg::RSP_TDATA_W-1:0]         rsp_tdata,
   output logic                                      rsp_tuser,
   output logic                                      rsp_tlast
);

   localparam int PW = rsbck_pkg::POS_W;

   logic [rsbck_pkg::SIZE_W-1:0]         width_ff;
   logic [rsbck_pkg::SIZE_W-1:0]         height_ff;
   logic [rsbck_pkg::COLOR_W-1:0]        key_ff;
   logic [rsbck_pkg::START_W-1:0]        start_x_ff;
   logic [rsbck_pkg::START_W-1:0]        start_y_ff;
   logic [rsbck_pkg::STEP_W-1:0]         cos_ff;
   logic [rsbck_pkg::STEP_W-1:0]         sin_ff;

   logic [PW-1:0]                        row_x_ff;
   logic [PW-1:0]                        row_y_ff;
   logic [PW-1:0]                        sample_x_ff;
   logic [PW-1:0]                        sample_y_ff;
   logic [rsbck_pkg::COUNT_W-1:0]        col_ff;
   logic [rsbck_pkg::COUNT_W-1:0]        row_ff;
   logic [PW-1:0]                        cur_x_ff;
   logic [PW-1:0]                        cur_y_ff;
   logic                                 done_ff;
   logic [rsbck_pkg::COLOR_W-1:0]        tex_ff;
   logic [rsbck_pkg::COLOR_W-1:0]        sprite_store_ff [rsbck_pkg::MAX_SPRITE_TEXELS];

   logic                                 out_valid_ff;
   logic                                 out_we_ff;
   logic [rsbck_pkg::PIX_W-1:0]          out_x_ff;
   logic [rsbck_pkg::PIX_W-1:0]          out_y_ff;
   logic [rsbck_pkg::COLOR_W-1:0]        out_color_ff;
   logic                                 out_last_ff;

   logic [rsbck_pkg::SIZE_W-1:0]         w;
   logic [rsbck_pkg::SIZE_W-1:0]         h;
   logic                                 draw_start;
   logic [PW-1:0]                        start_x_ext;
   logic [PW-1:0]                        start_y_ext;
   logic [PW-1:0]                        cos_ext;
   logic [PW-1:0]                        sin_ext;
   logic [PW-1:0]                        base_sx;
   logic [PW-1:0]                        base_sy;
   logic [PW-1:0]                        base_rx;
   logic [PW-1:0]                        base_ry;
   logic [rsbck_pkg::COUNT_W:0]          col_next;
   logic [rsbck_pkg::COUNT_W:0]          row_next;
   logic                                 last_col;
   logic                                 last_row;
   logic [rsbck_pkg::PROD_W-1:0]         addr_sum;
   logic [rsbck_pkg::ADDR_W-1:0]         rd_addr;
   logic [rsbck_pkg::ADDR_W-1:0]         load_addr;
   logic [rsbck_pkg::COLOR_W-1:0]        load_texel;
   logic signed [PW:0]                   vx;
   logic signed [PW:0]                   vy;
   logic                                 on_screen;
   logic                                 we;

   always_comb begin
      w           = rsbck_pkg::clamp_size(width_ff);
      h           = rsbck_pkg::clamp_size(height_ff);
      draw_start  = (col_ff == '0) && (row_ff == '0);
      start_x_ext = {{(PW - rsbck_pkg::START_W){start_x_ff[rsbck_pkg::START_W-1]}}, start_x_ff};
      start_y_ext = {{(PW - rsbck_pkg::START_W){start_y_ff[rsbck_pkg::START_W-1]}}, start_y_ff};
      cos_ext     = {{(PW - rsbck_pkg::STEP_W){cos_ff[rsbck_pkg::STEP_W-1]}}, cos_ff};
      sin_ext     = {{(PW - rsbck_pkg::STEP_W){sin_ff[rsbck_pkg::STEP_W-1]}}, sin_ff};
      base_sx     = draw_start ? start_x_ext : sample_x_ff;
      base_sy     = draw_start ? start_y_ext : sample_y_ff;
      base_rx     = draw_start ? start_x_ext : row_x_ff;
      base_ry     = draw_start ? start_y_ext : row_y_ff;
      col_next    = {1'b0, col_ff} + (rsbck_pkg::COUNT_W + 1)'(1);
      row_next    = {1'b0, row_ff} + (rsbck_pkg::COUNT_W + 1)'(1);
      last_col    = col_next >= {w, 1'b0};
      last_row    = row_next >= {h, 1'b0};
      addr_sum    = rsbck_pkg::PROD_W'(row_ff[rsbck_pkg::COUNT_W-1:1])
                    * rsbck_pkg::PROD_W'(w)
                    + rsbck_pkg::PROD_W'(col_ff[rsbck_pkg::COUNT_W-1:1]);
      rd_addr     = addr_sum[rsbck_pkg::ADDR_W-1:0];
      load_addr   = req_tdata[rsbck_pkg::ADDR_W-1:0];
      load_texel  = req_tdata[rsbck_pkg::ADDR_W +: rsbck_pkg::COLOR_W];
   end

   // Rounding adds one half and truncates toward zero, so a sample is on the
   // screen exactly when the biased position lies above minus one pixel and
   // below the screen edge.
   always_comb begin
      vx        = $signed({cur_x_ff[PW-1], cur_x_ff}) + rsbck_pkg::HALF_Q;
      vy        = $signed({cur_y_ff[PW-1], cur_y_ff}) + rsbck_pkg::HALF_Q;
      on_screen = (vx > rsbck_pkg::NEG_LIMIT) && (vx < rsbck_pkg::X_LIMIT)
                  && (vy > rsbck_pkg::NEG_LIMIT) && (vy < rsbck_pkg::Y_LIMIT);
      we        = on_screen && (tex_ff != key_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_go) begin
         sprite_store_ff[load_addr] <= load_texel;
      end
      if (cmd.step_go) begin
         tex_ff <= sprite_store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= rsbck_pkg::SIZE_MAX;
         height_ff    <= rsbck_pkg::SIZE_MAX;
         key_ff       <= rsbck_pkg::KEY_RESET;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         cos_ff       <= rsbck_pkg::COS_RESET;
         sin_ff       <= '0;
         row_x_ff     <= '0;
         row_y_ff     <= '0;
         sample_x_ff  <= '0;
         sample_y_ff  <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               rsbck_pkg::CSR_SPRITE_WIDTH:  width_ff   <= csr_data[rsbck_pkg::SIZE_W-1:0];
               rsbck_pkg::CSR_SPRITE_HEIGHT: height_ff  <= csr_data[rsbck_pkg::SIZE_W-1:0];
               rsbck_pkg::CSR_KEY_COLOR:     key_ff     <= csr_data[rsbck_pkg::COLOR_W-1:0];
               rsbck_pkg::CSR_START_X:       start_x_ff <= csr_data[rsbck_pkg::START_W-1:0];
               rsbck_pkg::CSR_START_Y:       start_y_ff <= csr_data[rsbck_pkg::START_W-1:0];
               rsbck_pkg::CSR_STEP_COS:      cos_ff     <= csr_data[rsbck_pkg::STEP_W-1:0];
               rsbck_pkg::CSR_STEP_SIN:      sin_ff     <= csr_data[rsbck_pkg::STEP_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.step_go) begin
            if (last_col) begin
               col_ff      <= '0;
               row_x_ff    <= base_rx - sin_ext;
               row_y_ff    <= base_ry + cos_ext;
               sample_x_ff <= base_rx - sin_ext;
               sample_y_ff <= base_ry + cos_ext;
               row_ff      <= last_row ? '0 : row_next[rsbck_pkg::COUNT_W-1:0];
            end else begin
               col_ff      <= col_next[rsbck_pkg::COUNT_W-1:0];
               row_x_ff    <= base_rx;
               row_y_ff    <= base_ry;
               sample_x_ff <= base_sx + cos_ext;
               sample_y_ff <= base_sy + sin_ext;
            end
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step_go) begin
         cur_x_ff <= base_sx;
         cur_y_ff <= base_sy;
         done_ff  <= last_col && last_row;
      end
      if (cmd.emit) begin
         out_we_ff    <= we;
         out_x_ff     <= (we && !vx[PW]) ? vx[16 +: rsbck_pkg::PIX_W] : '0;
         out_y_ff     <= (we && !vy[PW]) ? vy[16 +: rsbck_pkg::PIX_W] : '0;
         out_color_ff <= we ? tex_ff : '0;
         out_last_ff  <= done_ff;
      end
   end

   assign status.out_free = !out_valid_ff || rsp_tready;
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_tdata       = {{(rsbck_pkg::RSP_TDATA_W - rsbck_pkg::RSP_FIELD_W){1'b0}},
                             out_color_ff, out_y_ff, out_x_ff};
   assign rsp_tuser       = out_we_ff;
   assign rsp_tlast       = out_last_ff;

endmodule
`default_nettype wire

FILE: rtl/rotated_sprite_blit_color_key_unit.sv
// A step word registers its texel read and sample position when it is accepted, then its
// result word is registered into the output once the output is free; a load word writes
// the texel memory and gives no result. Loads are taken one per cycle while idle; after a
// step, req_tready stays low until its result word is registered, so a held output stalls.
// Reset clears the sample counts, positions and output valid and restores the register
// defaults; the texel memory is not cleared and holds garbage until loaded.
`default_nettype none
module rotated_sprite_blit_color_key_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // load_index [11:0], texel [35:12], zero [39:36]
   input  wire logic [rsbck_pkg::REQ_TDATA_W-1:0] req_tdata,
   // func [0]
   input  wire logic                              req_tuser,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [rsbck_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [rsbck_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // pixel_x [9:0], pixel_y [19:10], color [43:20], zero [47:44]
   output logic [rsbck_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // write_enable [0]
   output logic                                   rsp_tuser,
   output logic                                   rsp_tlast
);

   rsbck_pkg::cmd_type    cmd;
   rsbck_pkg::status_type status;

   assign csr_ready = 1'b1;

   rsbck_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   rsbck_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

FILE: rtl/rsbck_checker.sv
`default_nettype none
`include "rotated_sprite_blit_color_key_unit_assert.svh"
module rsbck_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              req_tuser,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [rsbck_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                              rsp_tuser,
   input wire logic                              rsp_tlast
);

   logic [rsbck_pkg::RSP_TDATA_W+1:0] rsp_word;
   logic                              rsp_stall;
   logic                              rsp_in_screen;
   logic                              load_idle;

   assign rsp_word      = {rsp_tlast, rsp_tuser, rsp_tdata};
   assign rsp_stall     = rsp_tvalid && !rsp_tready;
   assign rsp_in_screen = (rsp_tdata[9:0] < 10'(rsbck_pkg::SCREEN_WIDTH))
                          && (rsp_tdata[19:10] < 10'(rsbck_pkg::SCREEN_HEIGHT));
   assign load_idle     = req_tvalid && req_tready && !req_tuser && !rsp_tvalid;

   `RSBCK_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_word), "held word changed")

   `RSBCK_ASSERT_NOW(a_skip_zero, rsp_tvalid && !rsp_tuser, rsp_tdata == '0, "skip has data")

   `RSBCK_ASSERT_NOW(a_on_screen, rsp_tvalid && rsp_tuser, rsp_in_screen, "write off the screen")

   `RSBCK_ASSERT_NEXT(a_load_silent, load_idle, !rsp_tvalid, "load word produced a result word")

endmodule

bind rotated_sprite_blit_color_key_unit rsbck_checker u_rsbck_checker (.*);
`default_nettype wire

FILE: dv/rotated_sprite_blit_color_key_unit_test.sv
module rotated_sprite_blit_color_key_unit_test;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_STEP = 1'b1;
   localparam int SETUP_COUNT = 6;
   localparam int ITEMS_PER_SETUP = 115;
   localparam int PRELOAD_TEXELS = 512;
   localparam int HOLD_CYCLES = 80;

   typedef struct packed {
      logic                              we;
      logic [rsbck_pkg::PIX_W-1:0]       px;
      logic [rsbck_pkg::PIX_W-1:0]       py;
      logic [rsbck_pkg::COLOR_W-1:0]     color;
      logic                              done;
   } pixel_write_type;

   typedef struct {
      logic                              func;
      logic [rsbck_pkg::ADDR_W-1:0]      index;
      logic [rsbck_pkg::COLOR_W-1:0]     texel;
      logic                              typed;
      pixel_write_type                   want;
   } directed_row_type;

   typedef struct {
      logic [rsbck_pkg::SIZE_W-1:0]      w;
      logic [rsbck_pkg::SIZE_W-1:0]      h;
      logic [rsbck_pkg::COLOR_W-1:0]     key;
      logic [rsbck_pkg::START_W-1:0]     sx;
      logic [rsbck_pkg::START_W-1:0]     sy;
      logic [rsbck_pkg::STEP_W-1:0]      cs;
      logic [rsbck_pkg::STEP_W-1:0]      sn;
   } blit_setup_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [rsbck_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic req_tuser;
   logic csr_valid;
   logic csr_ready;
   logic [rsbck_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [rsbck_pkg::CSR_DATA_W-1:0] csr_data;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [rsbck_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;

   rotated_sprite_blit_color_key_unit dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always #1 clock = ~clock;

   logic [rsbck_pkg::COLOR_W-1:0] texel_mem [rsbck_pkg::MAX_SPRITE_TEXELS];
   logic [rsbck_pkg::SIZE_W-1:0] cfg_width = 7'd64;
   logic [rsbck_pkg::SIZE_W-1:0] cfg_height = 7'd64;
   logic [rsbck_pkg::COLOR_W-1:0] cfg_key = 24'hffffff;
   logic [rsbck_pkg::POS_W-1:0] cfg_start_x = '0;
   logic [rsbck_pkg::POS_W-1:0] cfg_start_y = '0;
   logic [rsbck_pkg::POS_W-1:0] cfg_cos = 32'd32768;
   logic [rsbck_pkg::POS_W-1:0] cfg_sin = '0;
   logic [rsbck_pkg::POS_W-1:0] row_px = '0;
   logic [rsbck_pkg::POS_W-1:0] row_py = '0;
   logic [rsbck_pkg::POS_W-1:0] pos_x = '0;
   logic [rsbck_pkg::POS_W-1:0] pos_y = '0;
   int col_cnt = 0;
   int row_cnt = 0;

   pixel_write_type pending_writes [$];
   logic [rsbck_pkg::COLOR_W-1:0] palette [4] = '{24'hffffff, 24'h000000, 24'hff00ff,
                                                  24'h00ff00};
   directed_row_type directed_rows [10];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic hold_armed = 1'b0;
   logic hold_served = 1'b0;
   int error_count = 0;
   int n_loads = 0;
   int n_samples = 0;
   int n_writes = 0;
   int n_draws = 0;

   function automatic int eff_size(input logic [rsbck_pkg::SIZE_W-1:0] s);
      if (s == 0) begin
         return 1;
      end
      if (s > 64) begin
         return 64;
      end
      return int'(s);
   endfunction

   function automatic int round_half(input logic [rsbck_pkg::POS_W-1:0] p);
      longint v;
      v = longint'($signed(p)) + 32768;
      return int'(v / 65536);
   endfunction

   function automatic pixel_write_type trace_sample();
      pixel_write_type r;
      int w;
      int h;
      int ix;
      int iy;
      int addr;
      logic [rsbck_pkg::COLOR_W-1:0] tex;
      logic hit;
      w = eff_size(cfg_width);
      h = eff_size(cfg_height);
      if (col_cnt == 0 && row_cnt == 0) begin
         row_px = cfg_start_x;
         pos_x = cfg_start_x;
         row_py = cfg_start_y;
         pos_y = cfg_start_y;
      end
      ix = round_half(pos_x);
      iy = round_half(pos_y);
      addr = ((row_cnt >> 1) * w + (col_cnt >> 1)) % rsbck_pkg::MAX_SPRITE_TEXELS;
      tex = texel_mem[addr];
      hit = ix >= 0 && ix < rsbck_pkg::SCREEN_WIDTH && iy >= 0
            && iy < rsbck_pkg::SCREEN_HEIGHT && tex != cfg_key;
      r = '0;
      if (col_cnt + 1 >= 2 * w) begin
         col_cnt = 0;
         row_px = row_px - cfg_sin;
         row_py = row_py + cfg_cos;
         pos_x = row_px;
         pos_y = row_py;
         if (row_cnt + 1 >= 2 * h) begin
            row_cnt = 0;
            r.done = 1'b1;
         end else begin
            row_cnt = (row_cnt + 1) & 127;
         end
      end else begin
         col_cnt = (col_cnt + 1) & 127;
         pos_x = pos_x + cfg_cos;
         pos_y = pos_y + cfg_sin;
      end
      if (hit) begin
         r.we = 1'b1;
         r.px = ix[rsbck_pkg::PIX_W-1:0];
         r.py = iy[rsbck_pkg::PIX_W-1:0];
         r.color = tex;
      end
      return r;
   endfunction

   function automatic logic [rsbck_pkg::COLOR_W-1:0] pick_texel();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(3))
         0: begin
            return palette[$urandom_range(3)];
         end
         1: begin
            return cfg_key;
         end
         default: begin
            return r[rsbck_pkg::COLOR_W-1:0];
         end
      endcase
   endfunction

   function automatic logic [rsbck_pkg::START_W-1:0] random_start(input int span);
      int v;
      v = (int'($urandom_range(span + 40)) - 20) * 65536 + int'($urandom_range(65535));
      return v[rsbck_pkg::START_W-1:0];
   endfunction

   function automatic logic [rsbck_pkg::STEP_W-1:0] random_step();
      int v;
      v = int'($urandom_range(65536)) - 32768;
      return v[rsbck_pkg::STEP_W-1:0];
   endfunction

   function automatic blit_setup_type make_setup(input int ph);
      blit_setup_type s;
      case (ph)
         0: begin
            s = '{7'd2, 7'd2, 24'hffffff, 27'(100 * 65536), 27'(50 * 65536),
                  17'd32768, 17'd0};
         end
         1: begin
            s = '{7'd0, 7'd127, 24'h000000, 27'h4000000, 27'h3ffffff,
                  17'(-32768), 17'd32768};
         end
         3: begin
            s = '{7'd64, 7'd1, 24'hff00ff, 27'(320 * 65536 + 32768), 27'(240 * 65536),
                  17'd0, 17'(-32768)};
         end
         5: begin
            s = '{7'd127, 7'd0, palette[$urandom_range(3)], 27'(639 * 65536 + 65535),
                  27'(479 * 65536 + 32767), 17'd23170, 17'(-23170)};
         end
         default: begin
            s.w = 7'($urandom_range(8, 1));
            s.h = 7'($urandom_range(8, 1));
            s.key = palette[$urandom_range(3)];
            s.sx = random_start(rsbck_pkg::SCREEN_WIDTH);
            s.sy = random_start(rsbck_pkg::SCREEN_HEIGHT);
            s.cs = random_step();
            s.sn = random_step();
         end
      endcase
      return s;
   endfunction

   task automatic check_field(input string name, input logic [rsbck_pkg::COLOR_W-1:0] want_v,
                              input logic [rsbck_pkg::COLOR_W-1:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         error_count++;
      end
   endtask

   task automatic send_word(input logic func, input logic [rsbck_pkg::ADDR_W-1:0] index,
                            input logic [rsbck_pkg::COLOR_W-1:0] texel, input logic typed,
                            input pixel_write_type want);
      pixel_write_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = func;
      req_tdata = {4'b0, texel, index};
      do @(posedge clock); while (!req_tready);
      if (func == FUNC_STEP) begin
         predicted = trace_sample();
         pending_writes.push_back(typed ? want : predicted);
         n_samples++;
      end else begin
         texel_mem[index] = texel;
         n_loads++;
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rsbck_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [rsbck_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         rsbck_pkg::CSR_SPRITE_WIDTH: cfg_width = value[rsbck_pkg::SIZE_W-1:0];
         rsbck_pkg::CSR_SPRITE_HEIGHT: cfg_height = value[rsbck_pkg::SIZE_W-1:0];
         rsbck_pkg::CSR_KEY_COLOR: cfg_key = value[rsbck_pkg::COLOR_W-1:0];
         rsbck_pkg::CSR_START_X: begin
            cfg_start_x = {{(rsbck_pkg::POS_W - rsbck_pkg::START_W)
                            {value[rsbck_pkg::START_W-1]}}, value};
         end
         rsbck_pkg::CSR_START_Y: begin
            cfg_start_y = {{(rsbck_pkg::POS_W - rsbck_pkg::START_W)
                            {value[rsbck_pkg::START_W-1]}}, value};
         end
         rsbck_pkg::CSR_STEP_COS: begin
            cfg_cos = {{(rsbck_pkg::POS_W - rsbck_pkg::STEP_W){value[rsbck_pkg::STEP_W-1]}},
                       value[rsbck_pkg::STEP_W-1:0]};
         end
         rsbck_pkg::CSR_STEP_SIN: begin
            cfg_sin = {{(rsbck_pkg::POS_W - rsbck_pkg::STEP_W){value[rsbck_pkg::STEP_W-1]}},
                       value[rsbck_pkg::STEP_W-1:0]};
         end
         default: begin
         end
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic apply_setup(input blit_setup_type s);
      write_reg(rsbck_pkg::CSR_SPRITE_WIDTH, rsbck_pkg::CSR_DATA_W'(s.w));
      write_reg(rsbck_pkg::CSR_SPRITE_HEIGHT, rsbck_pkg::CSR_DATA_W'(s.h));
      write_reg(rsbck_pkg::CSR_KEY_COLOR, rsbck_pkg::CSR_DATA_W'(s.key));
      write_reg(rsbck_pkg::CSR_START_X, s.sx);
      write_reg(rsbck_pkg::CSR_START_Y, s.sy);
      write_reg(rsbck_pkg::CSR_STEP_COS, rsbck_pkg::CSR_DATA_W'(s.cs));
      write_reg(rsbck_pkg::CSR_STEP_SIN, rsbck_pkg::CSR_DATA_W'(s.sn));
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_served) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_served = 1'b1;
         end
         rsp_tready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      pixel_write_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_writes.size() == 0) begin
            $error("result word with no sample waiting for it");
            error_count++;
         end else begin
            want = pending_writes.pop_front();
            check_field("write_enable", rsbck_pkg::COLOR_W'(want.we),
                        rsbck_pkg::COLOR_W'(rsp_tuser));
            check_field("pixel_x", rsbck_pkg::COLOR_W'(want.px),
                        rsbck_pkg::COLOR_W'(rsp_tdata[9:0]));
            check_field("pixel_y", rsbck_pkg::COLOR_W'(want.py),
                        rsbck_pkg::COLOR_W'(rsp_tdata[19:10]));
            check_field("color", want.color, rsp_tdata[43:20]);
            check_field("done_res", rsbck_pkg::COLOR_W'(want.done),
                        rsbck_pkg::COLOR_W'(rsp_tlast));
            n_writes += want.we;
            n_draws += want.done;
         end
      end
   end

   initial begin
      #2000000;
      $display("rotated_sprite_blit_color_key_unit: mismatch");
      $finish;
   end

   initial begin
      blit_setup_type setup;
      logic [31:0] r;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = FUNC_LOAD;
      csr_valid = 1'b0;
      csr_index = rsbck_pkg::CSR_SPRITE_WIDTH;
      csr_data = '0;
      directed_rows = '{
         '{FUNC_LOAD, 12'd0, 24'h123456, 1'b0, '0},
         '{FUNC_LOAD, 12'd1, 24'hffffff, 1'b0, '0},
         '{FUNC_LOAD, 12'd2, 24'h000000, 1'b0, '0},
         '{FUNC_LOAD, 12'hfff, 24'h800001, 1'b0, '0},
         '{FUNC_STEP, 12'd0, 24'd0, 1'b1, '{1'b1, 10'd0, 10'd0, 24'h123456, 1'b0}},
         '{FUNC_STEP, 12'd0, 24'd0, 1'b1, '{1'b1, 10'd1, 10'd0, 24'h123456, 1'b0}},
         '{FUNC_STEP, 12'd0, 24'd0, 1'b1, '{1'b0, 10'd0, 10'd0, 24'h000000, 1'b0}},
         '{FUNC_STEP, 12'd0, 24'd0, 1'b1, '{1'b0, 10'd0, 10'd0, 24'h000000, 1'b0}},
         '{FUNC_STEP, 12'd0, 24'd0, 1'b1, '{1'b1, 10'd2, 10'd0, 24'h000000, 1'b0}},
         '{FUNC_STEP, 12'd0, 24'd0, 1'b1, '{1'b1, 10'd3, 10'd0, 24'h000000, 1'b0}}
      };
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 33;
      recv_idle_pct = 75;
      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].func, directed_rows[i].index, directed_rows[i].texel,
                   directed_rows[i].typed, directed_rows[i].want);
      end
      // Every texel address that the setups below can reach lies in this range.
      for (int i = 0; i < PRELOAD_TEXELS; i++) begin
         send_word(FUNC_LOAD, i[rsbck_pkg::ADDR_W-1:0], pick_texel(), 1'b0, '0);
      end

      for (int ph = 0; ph < SETUP_COUNT; ph++) begin
         case (ph / 2)
            0: begin
               send_idle_pct = 33;
               recv_idle_pct = 75;
            end
            1: begin
               send_idle_pct = 75;
               recv_idle_pct = 33;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         settle();
         setup = make_setup(ph);
         apply_setup(setup);
         if (ph == 4) begin
            hold_armed = 1'b1;
         end
         for (int n = 0; n < ITEMS_PER_SETUP; n++) begin
            r = $urandom();
            if ($urandom_range(99) < 15) begin
               send_word(FUNC_LOAD, r[rsbck_pkg::ADDR_W-1:0], pick_texel(), 1'b0, '0);
            end else begin
               send_word(FUNC_STEP, r[rsbck_pkg::ADDR_W-1:0], r[31:8], 1'b0, '0);
            end
         end
      end
      settle();

      $display("Loaded %0d texels and stepped %0d samples across %0d register setups.",
               n_loads, n_samples, SETUP_COUNT);
      $display("Checked %0d framebuffer writes and %0d finished draws.", n_writes, n_draws);
      if (error_count == 0) begin
         $display("rotated_sprite_blit_color_key_unit: match");
      end else begin
         $display("rotated_sprite_blit_color_key_unit: mismatch");
      end
      $finish;
   end

endmodule

FILE: rotated_sprite_blit_color_key_unit.f
+incdir+rtl
rtl/rsbck_pkg.sv
rtl/rsbck_ctrl.sv
rtl/rsbck_datapath.sv
rtl/rotated_sprite_blit_color_key_unit.sv
rtl/rsbck_checker.sv
dv/rotated_sprite_blit_color_key_unit_test.sv
